// ===== design/salc_pkg.sv =====
// salc_pkg: shared constants and types for the set-associative cache core
// no dependencies
`timescale 1ns / 1ps
package salc_pkg;
  localparam int MAX_SETS = 256;
  localparam int WAYS = 4;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int SET_LIM = $clog2(MAX_SETS + 1) - 1;
  localparam int AGE_W = WAY_W;
  localparam int LN_W = 61;
  localparam int TAG_W = 63;
  localparam int ADDR_W = 64;
  localparam int CFG_W = 4;
  localparam int LB_MIN = 3;
  localparam int LB_MAX = 12;
  localparam logic [0:0] REG_SET_BITS = 1'b0;
  localparam logic [0:0] REG_LINE_BITS = 1'b1;

  typedef logic [TAG_W-1:0] tag_t;
  typedef logic [AGE_W-1:0] age_t;
  typedef tag_t [WAYS-1:0] tag_row_t;
  typedef age_t [WAYS-1:0] age_row_t;

  typedef struct packed {
    logic           we;
    logic [SET_W-1:0] waddr;
    tag_row_t       tags;
    age_row_t       ages;
  } row_wr_t;
endpackage

// ===== design/salc_if.sv =====
// salc_req_if, salc_rsp_if: valid/ready channels, each carrying one item
// no dependencies
`timescale 1ns / 1ps
interface salc_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [63:0] addr;
  modport source(output valid, op, addr, input ready);
  modport sink(input valid, op, addr, output ready);
endinterface

interface salc_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic        writeback;
  logic [63:0] writeback_addr;
  logic [63:0] fill_addr;
  modport source(output valid, hit, writeback, writeback_addr, fill_addr, input ready);
  modport sink(input valid, hit, writeback, writeback_addr, fill_addr, output ready);
endinterface

// ===== design/salc_set_mem.sv =====
// salc_set_mem: one row per set holding all tags and ages, registered read
// uses salc_pkg; rows initialized by a clearing sweep driven from the controller
`timescale 1ns / 1ps
module salc_set_mem import salc_pkg::*; (
  input  logic             clk,
  input  logic [SET_W-1:0] raddr,
  input  row_wr_t          wr,
  output tag_row_t         rtags,
  output age_row_t         rages
);
  tag_row_t tag_mem [MAX_SETS];
  age_row_t age_mem [MAX_SETS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      tag_mem[wr.waddr] <= wr.tags;
      age_mem[wr.waddr] <= wr.ages;
    end
    rtags <= tag_mem[raddr];
    rages <= age_mem[raddr];
  end
endmodule

// ===== design/salc_update.sv =====
// salc_update: lookup, victim choice and lru update on one set row
// uses salc_pkg
`timescale 1ns / 1ps
module salc_update import salc_pkg::*; (
  input  tag_row_t        tags,
  input  age_row_t        ages,
  input  logic            op,
  input  logic [LN_W-1:0] line,
  output logic            hit,
  output tag_t            victim,
  output tag_row_t        tags_next,
  output age_row_t        ages_next
);
  logic [WAY_W-1:0] hway;
  logic [WAY_W-1:0] vway;
  logic [WAY_W-1:0] way;
  age_t             t;

  always_comb begin
    hit  = 1'b0;
    hway = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (tags[i][62] && tags[i][LN_W-1:0] == line) begin
        hit  = 1'b1;
        hway = WAY_W'(i);
      end
    end
    vway = '0;
    for (int i = 1; i < WAYS; i++) begin
      if (ages[i] > ages[vway]) vway = WAY_W'(i);
    end
    way    = hit ? hway : vway;
    victim = tags[vway];
    t      = ages[way];
    tags_next = tags;
    if (hit) begin
      if (op) tags_next[way][61] = 1'b1;
    end else begin
      tags_next[way] = {1'b1, op, line};
    end
    for (int i = 0; i < WAYS; i++) begin
      ages_next[i] = (ages[i] < t) ? ages[i] + age_t'(1) : ages[i];
    end
    ages_next[way] = '0;
  end
endmodule

// ===== design/set_assoc_lru_writeback_cache_core.sv =====
// set_assoc_lru_writeback_cache_core: top level of the cache tag and lru engine
// uses salc_pkg, salc_if, salc_set_mem, salc_update
`timescale 1ns / 1ps
// Each access reads the set row (all tags and ages of the set) from a
// synchronous memory as it is accepted, then looks it up, updates it and
// writes it back in ST_LOOK while the result lands in an output register.
// No new item is accepted before that or while a result waits, so the next
// item's read follows the write-back and no forwarding is needed. After
// reset a clearing pass fills all MAX_SETS rows with invalid tags and
// initial ages; no item is accepted meanwhile.
module set_assoc_lru_writeback_cache_core import salc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [3:0]   cfg_data,
  salc_req_if.sink     req,
  salc_rsp_if.source   rsp
);
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;

  logic [1:0]        state;
  logic [SET_W:0]    clr_cnt;
  logic [CFG_W-1:0]  set_bits;
  logic [CFG_W-1:0]  line_bits;
  logic              op_q;
  logic [ADDR_W-1:0] addr_q;
  logic [SET_W-1:0]  set_q;

  logic [3:0]        lb;
  logic [3:0]        sb;
  logic [ADDR_W-1:0] line_full;
  logic [ADDR_W-1:0] lmask;
  logic [SET_W-1:0]  set_idx;
  logic              acc;

  tag_row_t rtags, tags_next;
  age_row_t rages, ages_next, init_ages;
  row_wr_t  wr;
  logic     hit;
  tag_t     victim;

  // effective register values
  always_comb begin
    lb = (line_bits < 4'(LB_MIN)) ? 4'(LB_MIN) :
         (line_bits > 4'(LB_MAX)) ? 4'(LB_MAX) : line_bits;
    sb = (set_bits > 4'(SET_LIM)) ? 4'(SET_LIM) : set_bits;
    line_full = req.addr >> lb;
    set_idx   = SET_W'(line_full & ((64'd1 << sb) - 64'd1));
    lmask     = (64'd1 << lb) - 64'd1;
    for (int j = 0; j < WAYS; j++) init_ages[j] = age_t'(WAYS - j - 1);
  end

  assign req.ready = (state == ST_IDLE) && (!rsp.valid || rsp.ready);
  assign acc = req.valid && req.ready;

  salc_set_mem u_mem (
    .clk(clk), .raddr(set_idx), .wr(wr), .rtags(rtags), .rages(rages)
  );

  salc_update u_upd (
    .tags(rtags), .ages(rages), .op(op_q),
    .line(LN_W'(addr_q >> lb)),
    .hit(hit), .victim(victim), .tags_next(tags_next), .ages_next(ages_next)
  );

  always_comb begin
    wr = '0;
    if (state == ST_CLEAR) begin
      wr.we    = 1'b1;
      wr.waddr = clr_cnt[SET_W-1:0];
      wr.tags  = '0;
      wr.ages  = init_ages;
    end else if (state == ST_LOOK) begin
      wr.we    = 1'b1;
      wr.waddr = set_q;
      wr.tags  = tags_next;
      wr.ages  = ages_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      set_bits  <= 4'd6;
      line_bits <= 4'd6;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_SET_BITS) set_bits <= cfg_data;
        else line_bits <= cfg_data;
      end
      if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == (SET_W+1)'(MAX_SETS - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (acc) state <= ST_LOOK;
        end
        ST_LOOK: begin
          state     <= ST_IDLE;
          rsp.valid <= 1'b1;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (acc) begin
      op_q   <= req.op;
      addr_q <= req.addr;
      set_q  <= set_idx;
    end
    if (state == ST_LOOK) begin
      rsp.hit <= hit;
      if (hit) begin
        rsp.writeback      <= 1'b0;
        rsp.writeback_addr <= '0;
        rsp.fill_addr      <= '0;
      end else begin
        rsp.writeback      <= victim[62] & victim[61];
        rsp.writeback_addr <= (victim[62] & victim[61]) ?
                              (ADDR_W'(victim[LN_W-1:0]) << lb) : '0;
        rsp.fill_addr      <= addr_q & ~lmask;
      end
    end
  end
endmodule

// ===== design/salc_checker.sv =====
// salc_checker: port-level assertions for the cache core, bound to the top level
// no dependencies
`timescale 1ns / 1ps
module salc_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic hit,
  input logic writeback,
  input logic [63:0] writeback_addr,
  input logic [63:0] fill_addr
);
  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && hit |-> !writeback && fill_addr == 64'd0 && writeback_addr == 64'd0)
    else $error("hit carries miss data");
  a_no_wb_addr: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !writeback |-> writeback_addr == 64'd0)
    else $error("writeback address without writeback");
  a_one_out: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("accepted two items back to back");
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(fill_addr))
    else $error("result dropped while stalled");
endmodule

bind set_assoc_lru_writeback_cache_core salc_checker u_chk (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .hit(rsp.hit),
  .writeback(rsp.writeback), .writeback_addr(rsp.writeback_addr),
  .fill_addr(rsp.fill_addr)
);

// ===== verif/salc_tb_if.sv =====
// local copies are not needed: the design interfaces live in design/salc_if.sv
// this file holds no declarations beyond the timescale; interfaces come from the design
`timescale 1ns / 1ps

// ===== verif/set_assoc_lru_writeback_cache_core_tb.sv =====
// testbench for set_assoc_lru_writeback_cache_core: random and directed accesses
// checked against a behavioral lru cache predictor; uses salc_pkg and salc_if
`timescale 1ns / 1ps

class cache_scoreboard;
  logic [3:0] set_bits_q, line_bits_q;
  logic [62:0] tags [salc_pkg::MAX_SETS*salc_pkg::WAYS];
  int unsigned ages [salc_pkg::MAX_SETS*salc_pkg::WAYS];
  logic [193:0] pending [$];
  bit failed;

  function void clear_state();
    set_bits_q = 6; line_bits_q = 6; failed = 0;
    for (int s = 0; s < salc_pkg::MAX_SETS; s++)
      for (int j = 0; j < salc_pkg::WAYS; j++) begin
        tags[s*salc_pkg::WAYS+j] = '0;
        ages[s*salc_pkg::WAYS+j] = salc_pkg::WAYS - j - 1;
      end
  endfunction

  function void write_reg(logic idx, logic [3:0] val);
    if (idx == salc_pkg::REG_SET_BITS) set_bits_q = val;
    else line_bits_q = val;
  endfunction

  // bump everything younger than the touched way, then make it youngest
  function void touch_way(int base, int w);
    int unsigned t;
    t = ages[base+w];
    for (int i = 0; i < salc_pkg::WAYS; i++)
      if (ages[base+i] < t) ages[base+i]++;
    ages[base+w] = 0;
  endfunction

  function void note_access(logic op, logic [63:0] addr);
    int lb, sb, base, w;
    logic [63:0] line, wb_addr;
    logic [62:0] victim;
    lb = line_bits_q < 3 ? 3 : (line_bits_q > 12 ? 12 : line_bits_q);
    sb = set_bits_q > salc_pkg::SET_LIM ? salc_pkg::SET_LIM : set_bits_q;
    line = addr >> lb;
    base = int'(line & ((64'd1 << sb) - 1)) * salc_pkg::WAYS;
    for (int i = 0; i < salc_pkg::WAYS; i++)
      if (tags[base+i][62] && tags[base+i][60:0] == line[60:0]) begin
        touch_way(base, i);
        if (op) tags[base+i][61] = 1'b1;
        pending.push_back({1'b1, 1'b0, 64'd0, 64'd0, 64'd0});
        return;
      end
    w = 0;
    for (int i = 1; i < salc_pkg::WAYS; i++)
      if (ages[base+i] > ages[base+w]) w = i;
    victim = tags[base+w];
    tags[base+w] = {1'b1, op, line[60:0]};
    touch_way(base, w);
    wb_addr = (victim[62] && victim[61]) ? ({3'b0, victim[60:0]} << lb) : 64'd0;
    pending.push_back({1'b0, victim[62] & victim[61], wb_addr,
                       addr & ~((64'd1 << lb) - 1), 64'd0});
  endfunction

  function void check_result(logic hit, logic wb, logic [63:0] wba, logic [63:0] fa);
    logic [193:0] e;
    if (pending.size() == 0) begin
      $display("%0t unexpected result hit=%b wb=%b", $time, hit, wb);
      failed = 1;
      return;
    end
    e = pending.pop_front();
    if (e[193] !== hit) begin
      $display("%0t hit exp %b got %b", $time, e[193], hit); failed = 1;
    end
    if (e[192] !== wb) begin
      $display("%0t writeback exp %b got %b", $time, e[192], wb); failed = 1;
    end
    if (e[191:128] !== wba) begin
      $display("%0t writeback_addr exp %h got %h", $time, e[191:128], wba); failed = 1;
    end
    if (e[127:64] !== fa) begin
      $display("%0t fill_addr exp %h got %h", $time, e[127:64], fa); failed = 1;
    end
  endfunction
endclass

module set_assoc_lru_writeback_cache_core_tb;
  import salc_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [0:0] cfg_index = REG_SET_BITS;
  logic [3:0] cfg_data = '0;
  int cycles = 0;
  bit no_idle = 0;      // stretch with no idling on either side
  int hold_off = 0;     // long receiver stall, counted down in the receiver process

  salc_req_if req ();
  salc_rsp_if rsp ();
  cache_scoreboard sb = new();

  set_assoc_lru_writeback_cache_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .req(req), .rsp(rsp)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // timeout: clearing pass plus items at worst stalls, several times over
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    req.valid = 0; req.op = 0; req.addr = '0;
    rsp.ready = 0;
  end

  // receiver: random stalls, plus a long hold-off when asked
  always @(negedge clk) begin
    if (hold_off > 0) begin
      rsp.ready <= 0;
      hold_off <= hold_off - 1;
    end else
      rsp.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 7);
  end

  // results checked at the rising edge
  always @(posedge clk)
    if (!rst && rsp.valid && rsp.ready)
      sb.check_result(rsp.hit, rsp.writeback, rsp.writeback_addr, rsp.fill_addr);

  // one access: offer at the falling edge, note at the accepting rising edge
  // valid stays up after the accept; the next item, an idle cycle or drain() lowers it
  task automatic send_access(logic op, logic [63:0] addr);
    while (!no_idle && $urandom_range(99) < 7) begin
      req.valid <= 0;
      @(negedge clk);
    end
    req.valid <= 1; req.op <= op; req.addr <= addr;
    do @(posedge clk); while (!req.ready);
    sb.note_access(op, addr);
    @(negedge clk);
  endtask

  task automatic drain();
    req.valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [3:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, val);
    @(negedge clk);
  endtask

  // addresses in a small window of lines so sets fill and evict often
  function automatic logic [63:0] near_addr(int lb, int sbits);
    logic [63:0] a;
    a = {$urandom, $urandom};
    a[lb +: 16] = 16'($urandom_range(3));
    a[lb + sbits +: 3] = 3'($urandom_range(7));
    if ($urandom_range(9) != 0) a = a & ((64'd1 << (lb + sbits + 3)) - 64'd1);
    return a;
  endfunction

  initial begin
    logic [3:0] sbs [6] = '{4'd0, 4'd15, 4'd8, 4'd2, 4'd1, 4'd6};
    logic [3:0] lbs [6] = '{4'd0, 4'd15, 4'd3, 4'd12, 4'd5, 4'd6};
    int lb, sbits;
    sb.clear_state();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: extremes of address, both ops, hits, several-way evictions
    send_access(1'b1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(1'b0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(1'b0, 64'd0);
    send_access(1'b1, 64'd0);
    for (int k = 1; k <= 6; k++) send_access(1'b1, 64'(k) << 12);
    for (int k = 1; k <= 6; k++) send_access(1'b0, 64'(k) << 12);
    send_access(1'b0, 64'hAAAA_AAAA_AAAA_AAAA);
    send_access(1'b1, 64'h5555_5555_5555_5555);
    send_access(1'b0, 64'h5555_5555_5555_5555);
    drain();

    // phases over settings, register changes while lines are held
    for (int p = 0; p < 6; p++) begin
      write_cfg(REG_SET_BITS, sbs[p]);
      write_cfg(REG_LINE_BITS, lbs[p]);
      lb = lbs[p] < 3 ? 3 : (lbs[p] > 12 ? 12 : lbs[p]);
      sbits = sbs[p] > SET_LIM ? SET_LIM : sbs[p];
      no_idle = (p == 2);
      if (p == 3) hold_off = 300;   // block fills up and stalls its input
      for (int n = 0; n < 90; n++)
        send_access(1'($urandom_range(1)), $urandom_range(4) == 0 ?
                    {$urandom, $urandom} : near_addr(lb, sbits));
      no_idle = 0;
      drain();                      // sender pauses until all results are in
    end

    if (sb.failed == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
